>>> sv/horizon_edge_finder_defines.svh
// Assertion macros for the horizon edge finder.
// Used by horizon_edge_finder.sv; expects aclk and aresetn in scope.
`ifndef HORIZON_EDGE_FINDER_DEFINES_SVH
`define HORIZON_EDGE_FINDER_DEFINES_SVH

// Same-cycle implication, disabled while in reset
`define HEF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset
`define HEF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/hef_pkg.sv
// Types, constants and the per-lane window check for the horizon edge finder.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package hef_pkg;

    // Profile length limits per pass
    localparam int unsigned MAX_HEIGHT = 1024;
    localparam int unsigned MAX_WIDTH  = 1024;

    localparam int unsigned SAMPLE_W = 8;
    localparam int unsigned POS_W    = 10;
    localparam int unsigned IDX_W    = 11;
    localparam int unsigned CFG_W    = 10;
    localparam int unsigned NUM_LANES = 4;

    localparam logic [IDX_W-1:0] WIN_SPAN     = 11'd3;
    localparam logic [IDX_W-1:0] IDX_LIMIT    = 11'd2047;
    localparam logic [IDX_W-1:0] HEIGHT_LIMIT = IDX_W'(MAX_HEIGHT);
    localparam logic [IDX_W-1:0] WIDTH_LIMIT  = IDX_W'(MAX_WIDTH);

    // Direction codes (two's complement)
    localparam logic [1:0] DIR_NONE = 2'b00;
    localparam logic [1:0] DIR_RISE = 2'b01;
    localparam logic [1:0] DIR_FALL = 2'b11;

    // Lock codes
    localparam logic [1:0] LOCK_NONE = 2'd0;
    localparam logic [1:0] LOCK_FALL = 2'd1;
    localparam logic [1:0] LOCK_RISE = 2'd2;

    // Pass select
    localparam logic FUNC_COLUMN = 1'b0;
    localparam logic FUNC_ROW    = 1'b1;

    // Register indexes
    localparam logic [2:0] REG_COL_THR     = 3'd0;
    localparam logic [2:0] REG_ROW_THR     = 3'd1;
    localparam logic [2:0] REG_COL_MIN_IDX = 3'd2;
    localparam logic [2:0] REG_ROW_MIN_IDX = 3'd3;

    // Register reset values
    localparam logic [SAMPLE_W-1:0] COL_THR_RESET     = 8'd140;
    localparam logic [SAMPLE_W-1:0] ROW_THR_RESET     = 8'd170;
    localparam logic [POS_W-1:0]    COL_MIN_IDX_RESET = 10'd6;
    localparam logic [POS_W-1:0]    ROW_MIN_IDX_RESET = 10'd0;

    typedef struct packed {
        logic             found;
        logic [1:0]       lock;
        logic [POS_W-1:0] position;
        logic [1:0]       direction;
    } lane_t;

    localparam lane_t LANE_CLEAR = '{found: 1'b0, lock: LOCK_NONE,
                                     position: '0, direction: DIR_NONE};

    // One window test: old is s[i], now is s[i+3]
    function automatic lane_t check_lane(
        input lane_t               cur,
        input logic                en,
        input logic [SAMPLE_W-1:0] old,
        input logic [SAMPLE_W-1:0] now,
        input logic [POS_W-1:0]    win,
        input logic [SAMPLE_W-1:0] thr,
        input logic [POS_W-1:0]    min_idx
    );
        lane_t              res;
        logic signed [8:0]  diff;
        logic               bright;
        res    = cur;
        diff   = $signed({1'b0, now}) - $signed({1'b0, old});
        bright = (old > thr);
        if (en && bright && (diff <= -9'sd3) && (cur.lock != LOCK_RISE)) begin
            res.found     = 1'b1;
            res.lock      = LOCK_FALL;
            res.position  = win;
            res.direction = DIR_FALL;
        end else if (en && bright && (diff >= 9'sd3) && !cur.found && (win >= min_idx)) begin
            res.found     = 1'b1;
            res.lock      = LOCK_RISE;
            res.position  = win;
            res.direction = DIR_RISE;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

>>> sv/horizon_edge_finder.sv
// Horizon edge finder: one sample pair per cycle, edge search on four lanes.
// Lane state updates at the accepting edge; on a frame-end transfer the four
// results start next cycle, then go out one per cycle unless stalled (edge 0..3).
// Throughput: one input transfer per cycle; only a frame-end item waits while
// the previous frame's results are still being sent (set by the result buffer).
// Reset (aresetn low, synchronous): registers to defaults, lanes, delays cleared.
`timescale 1ns / 1ps
`default_nettype none

module horizon_edge_finder (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [7:0] sample_a, [15:8] sample_b
    input  wire logic [1:0]  s_tuser,   // [0] func, [1] pass_start
    input  wire logic        s_tlast,   // frame_end
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [9:0] position, [11:10] direction,
                                        // [15:12] zero
    output logic [1:0]       m_tuser,   // [1:0] edge_id
    output logic             m_tlast,   // last
    // configuration writes
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [9:0]  cfg_data
);
    import hef_pkg::*;

    `include "horizon_edge_finder_defines.svh"

    // Configuration registers
    logic [SAMPLE_W-1:0] col_thr_reg, row_thr_reg;
    logic [POS_W-1:0]    col_min_reg, row_min_reg;

    // Datapath state
    logic [SAMPLE_W-1:0] delay_a_reg [3];
    logic [SAMPLE_W-1:0] delay_b_reg [3];
    logic [IDX_W-1:0]    idx_reg, idx_next;
    lane_t               lane_reg  [NUM_LANES];
    lane_t               lane_next [NUM_LANES];

    // Result buffer
    logic [POS_W-1:0]    snap_pos_reg [NUM_LANES];
    logic [1:0]          snap_dir_reg [NUM_LANES];
    logic [1:0]          emit_cnt_reg;
    logic                m_tvalid_reg;

    logic                in_xfer, out_xfer, out_done;
    logic                func, pass_start;
    logic [SAMPLE_W-1:0] sa, sb;
    logic [IDX_W-1:0]    idx_eff, limit;
    logic                win_en;
    logic [POS_W-1:0]    win;
    logic [SAMPLE_W-1:0] thr;
    logic [POS_W-1:0]    min_idx;
    lane_t               lane_clr [NUM_LANES];

    assign func       = s_tuser[0];
    assign pass_start = s_tuser[1];
    assign sa         = s_tdata[7:0];
    assign sb         = s_tdata[15:8];

    // Handshakes: a frame-end item waits only while old results are pending
    assign out_xfer  = m_tvalid_reg && m_tready;
    assign out_done  = out_xfer && (emit_cnt_reg == 2'd3);
    assign s_tready  = !m_tvalid_reg || out_done || !s_tlast;
    assign in_xfer   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // Window selection for this sample
    always_comb begin
        idx_eff = pass_start ? '0 : idx_reg;
        limit   = (func == FUNC_ROW) ? WIDTH_LIMIT : HEIGHT_LIMIT;
        win_en  = (idx_eff >= WIN_SPAN) && (idx_eff < limit);
        win     = POS_W'(idx_eff - WIN_SPAN);
        thr     = (func == FUNC_ROW) ? row_thr_reg : col_thr_reg;
        min_idx = (func == FUNC_ROW) ? row_min_reg : col_min_reg;
        idx_next = (idx_eff < IDX_LIMIT) ? idx_eff + 11'd1 : idx_eff;
    end

    // Lane clearing on pass start, then the window checks
    always_comb begin
        for (int n = 0; n < NUM_LANES; n++) begin
            lane_clr[n] = lane_reg[n];
        end
        if (pass_start) begin
            lane_clr[2] = LANE_CLEAR;
            lane_clr[3] = LANE_CLEAR;
            if (func == FUNC_COLUMN) begin
                lane_clr[0] = LANE_CLEAR;
                lane_clr[1] = LANE_CLEAR;
            end
        end
        lane_next[0] = check_lane(lane_clr[0], win_en && (func == FUNC_COLUMN),
                                  delay_a_reg[2], sa, win, thr, min_idx);
        lane_next[1] = check_lane(lane_clr[1], win_en && (func == FUNC_COLUMN),
                                  delay_b_reg[2], sb, win, thr, min_idx);
        lane_next[2] = check_lane(lane_clr[2], win_en && (func == FUNC_ROW),
                                  delay_a_reg[2], sa, win, thr, min_idx);
        lane_next[3] = check_lane(lane_clr[3], win_en && (func == FUNC_ROW),
                                  delay_b_reg[2], sb, win, thr, min_idx);
    end

    // Configuration registers; writes past the last index are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_thr_reg <= COL_THR_RESET;
            row_thr_reg <= ROW_THR_RESET;
            col_min_reg <= COL_MIN_IDX_RESET;
            row_min_reg <= ROW_MIN_IDX_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_COL_THR:     col_thr_reg <= cfg_data[7:0];
                REG_ROW_THR:     row_thr_reg <= cfg_data[7:0];
                REG_COL_MIN_IDX: col_min_reg <= cfg_data;
                REG_ROW_MIN_IDX: row_min_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Delay lines, sample index and lane state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < 3; k++) begin
                delay_a_reg[k] <= '0;
                delay_b_reg[k] <= '0;
            end
            idx_reg <= '0;
            for (int n = 0; n < NUM_LANES; n++) begin
                lane_reg[n] <= LANE_CLEAR;
            end
        end else if (in_xfer) begin
            delay_a_reg[2] <= delay_a_reg[1];
            delay_a_reg[1] <= delay_a_reg[0];
            delay_a_reg[0] <= sa;
            delay_b_reg[2] <= delay_b_reg[1];
            delay_b_reg[1] <= delay_b_reg[0];
            delay_b_reg[0] <= sb;
            idx_reg <= idx_next;
            for (int n = 0; n < NUM_LANES; n++) begin
                lane_reg[n] <= lane_next[n];
            end
        end
    end

    // Result buffer: snapshot at frame end, then one result per transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
            emit_cnt_reg <= '0;
        end else if (in_xfer && s_tlast) begin
            m_tvalid_reg <= 1'b1;
            emit_cnt_reg <= '0;
        end else if (out_xfer) begin
            emit_cnt_reg <= emit_cnt_reg + 2'd1;
            if (emit_cnt_reg == 2'd3) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_xfer && s_tlast) begin
            for (int n = 0; n < NUM_LANES; n++) begin
                snap_pos_reg[n] <= lane_next[n].position;
                snap_dir_reg[n] <= lane_next[n].direction;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'b0000, snap_dir_reg[emit_cnt_reg], snap_pos_reg[emit_cnt_reg]};
    assign m_tuser  = emit_cnt_reg;
    assign m_tlast  = (emit_cnt_reg == 2'd3);

    // Checks
    `HEF_ASSERT_NEXT(a_frame_end_starts_results, in_xfer && s_tlast,
        m_tvalid_reg && (emit_cnt_reg == 2'd0), "results did not start after frame end")
    `HEF_ASSERT_NEXT(a_rise_lock_holds,
        (lane_reg[0].lock == LOCK_RISE) && !(in_xfer && pass_start),
        $stable(lane_reg[0].position) && (lane_reg[0].direction == DIR_RISE),
        "rise-locked lane changed without a pass start")
    `HEF_ASSERT_NOW(a_unfound_lane_empty, !lane_reg[2].found,
        (lane_reg[2].direction == DIR_NONE) && (lane_reg[2].lock == LOCK_NONE),
        "lane without a hit carries a direction or lock")

endmodule

`default_nettype wire
